/* sv/csjd_pkg.sv */
`timescale 1ns / 1ps

package csjd_pkg;

    localparam int MAX_KEPT  = 64;
    localparam int KEPT_AW   = $clog2(MAX_KEPT);
    localparam int CNT_W     = $clog2(MAX_KEPT + 1);
    localparam int SET_BITS  = 256;
    localparam int CHUNK_W   = 32;
    localparam int CHUNKS    = SET_BITS / CHUNK_W;
    localparam int CHUNK_AW  = $clog2(CHUNKS);
    localparam int POP_W     = $clog2(SET_BITS + 1);
    localparam int THR_W     = 17;
    localparam int PROD_W    = THR_W + POP_W;

    localparam logic [THR_W-1:0] THR_RESET = 17'd58982;
    localparam logic [THR_W-1:0] Q16_ONE   = 17'd65536;

    localparam logic [1:0] CMD_KEPT  = 2'd0;
    localparam logic [1:0] CMD_CAND  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] title_byte;
        logic       byte_valid;
        logic       title_last;
    } in_word_t;

    typedef struct packed {
        logic               keep;
        logic [KEPT_AW-1:0] match_index;
        logic               table_full;
        logic [CNT_W-1:0]   kept_count;
    } out_word_t;

    // A-Z folded to a-z, everything else unchanged
    function automatic logic [7:0] lower_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b | 8'h20;
        end
        return r;
    endfunction

    function automatic logic [POP_W-1:0] popcount_chunk(input logic [CHUNK_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < CHUNK_W; i++)
        begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

endpackage

/* sv/char_set_jaccard_dedup.sv */
`timescale 1ns / 1ps

// Character-set near-duplicate filter. Each input word is one title byte;
// bytes fold (A-Z lowered) into a 256-bit set of distinct characters. On a
// kept-title end the set is stored (up to MAX_KEPT entries, else dropped
// with table_full); on a candidate end it is compared with every stored set
// and dropped (keep = 0) at the first entry whose intersection*65536 >=
// threshold_q16*union. A clear word empties the table and gives no result.
// Flow: a byte that does not end a title, a clear word or an ignored word
// leaves the block idle and ready. A kept-title end passes through the
// done state before the next word is taken. A candidate end walks the
// stored entries up to the first match: each entry costs one table read,
// 32-bit intersection and union popcounts stepped over the 256-bit row,
// one multiply and one compare. The result sits in an output register, so
// bytes of the next title keep flowing while it waits to be taken; a title
// end that finds the previous result still waiting holds in its last cycle
// until that one is taken.
module char_set_jaccard_dedup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  csjd_pkg::in_word_t            in_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output csjd_pkg::out_word_t           out_word,
    input  logic                          cfg_we,
    input  logic [csjd_pkg::THR_W-1:0]    cfg_wdata
);
    import csjd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]          state_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [SET_BITS-1:0] bset_reg;
    logic [CNT_W-1:0]    total_reg;
    logic [KEPT_AW-1:0]  idx_reg;
    logic [CHUNK_AW-1:0] chunk_reg;
    logic [POP_W-1:0]    inter_reg;
    logic [POP_W-1:0]    uni_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                keep_reg;
    logic                full_reg;
    logic [KEPT_AW-1:0]  match_reg;
    logic                out_valid_reg;
    out_word_t           out_reg;

    logic [SET_BITS-1:0] mem [MAX_KEPT];
    logic [SET_BITS-1:0] row_reg;

    logic                accept;
    logic [7:0]          low_b;
    logic [SET_BITS-1:0] folded;
    logic                mem_we;
    logic [CHUNK_W-1:0]  a_chunk;
    logic [CHUNK_W-1:0]  b_chunk;
    logic                hit;
    logic                out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign low_b  = lower_byte(in_word.title_byte);
    assign folded = in_word.byte_valid ? (bset_reg | (SET_BITS'(1) << low_b)) : bset_reg;

    assign mem_we = accept && in_word.title_last && (in_word.cmd == CMD_KEPT)
                    && (total_reg < CNT_W'(MAX_KEPT));

    assign a_chunk = bset_reg[chunk_reg*CHUNK_W +: CHUNK_W];
    assign b_chunk = row_reg[chunk_reg*CHUNK_W +: CHUNK_W];

    // empty union means both sets empty: similarity one
    assign hit = (uni_reg == '0) ? (thr_reg <= Q16_ONE)
               : (PROD_W'({inter_reg, 16'h0000}) >= prod_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[total_reg[KEPT_AW-1:0]] <= folded;
        end
        if (state_reg == ST_RD)
        begin
            row_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= THR_RESET;
            bset_reg      <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            chunk_reg     <= '0;
            inter_reg     <= '0;
            uni_reg       <= '0;
            prod_reg      <= '0;
            keep_reg      <= 1'b0;
            full_reg      <= 1'b0;
            match_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_word.cmd == CMD_CLEAR)
                        begin
                            total_reg <= '0;
                            bset_reg  <= '0;
                        end
                        else if (in_word.cmd == CMD_KEPT || in_word.cmd == CMD_CAND)
                        begin
                            if (!in_word.title_last)
                            begin
                                bset_reg <= folded;
                            end
                            else if (in_word.cmd == CMD_KEPT)
                            begin
                                bset_reg  <= '0;
                                match_reg <= '0;
                                state_reg <= ST_DONE;
                                if (mem_we)
                                begin
                                    total_reg <= total_reg + 1'b1;
                                    keep_reg  <= 1'b1;
                                    full_reg  <= 1'b0;
                                end
                                else
                                begin
                                    keep_reg <= 1'b0;
                                    full_reg <= 1'b1;
                                end
                            end
                            else
                            begin
                                bset_reg  <= folded;
                                keep_reg  <= 1'b1;
                                full_reg  <= 1'b0;
                                match_reg <= '0;
                                idx_reg   <= '0;
                                state_reg <= (total_reg == '0) ? ST_DONE : ST_RD;
                            end
                        end
                    end
                end
                ST_RD:
                begin
                    chunk_reg <= '0;
                    inter_reg <= '0;
                    uni_reg   <= '0;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    inter_reg <= inter_reg + popcount_chunk(a_chunk & b_chunk);
                    uni_reg   <= uni_reg + popcount_chunk(a_chunk | b_chunk);
                    chunk_reg <= chunk_reg + 1'b1;
                    if (chunk_reg == CHUNK_AW'(CHUNKS - 1))
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= PROD_W'(thr_reg) * PROD_W'(uni_reg);
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (hit)
                    begin
                        keep_reg  <= 1'b0;
                        match_reg <= idx_reg;
                        state_reg <= ST_DONE;
                    end
                    else if (CNT_W'(idx_reg) + 1'b1 == total_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg.keep        <= keep_reg;
                        out_reg.match_index <= match_reg;
                        out_reg.table_full  <= full_reg;
                        out_reg.kept_count  <= total_reg;
                        bset_reg            <= '0;
                        state_reg           <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(MAX_KEPT))
        else $error("stored count above table size");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD |-> CNT_W'(idx_reg) < total_reg)
        else $error("walk reads past stored entries");

    a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.keep && out_reg.table_full))
        else $error("kept and table_full both set");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_word.cmd == CMD_CLEAR |=> total_reg == '0)
        else $error("clear left stored entries");
`endif

endmodule
